@@ sv/peer_presence_aging_table_defines.svh @@
// assertion macros for the peer presence aging table
// expects i_clk and the active-low synchronous reset i_rst_n in the using scope
`ifndef PEER_PRESENCE_AGING_TABLE_DEFINES_SVH
`define PEER_PRESENCE_AGING_TABLE_DEFINES_SVH

// same-cycle implication
`define PPAT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PPAT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ppat_pkg.sv @@
// constants and codes for the peer presence aging table
// no dependencies
package ppat_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 32;
    localparam int KEY_BITS_DEFAULT    = 48;
    localparam int STAMP_W             = 32;
    localparam int CFG_DATA_W          = 32;
    localparam int CNT_OUT_W           = 6;
    localparam int OUT_TDATA_W         = 16;

    localparam logic [STAMP_W-1:0] RESET_TIMEOUT = 32'd60;

    // configuration register indexes
    localparam logic CFG_LIVE_TIMEOUT   = 1'b0;
    localparam logic CFG_CHECK_INTERVAL = 1'b1;

    // item kinds
    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_ANNOUNCE = 1'b1;

endpackage

@@ sv/peer_presence_aging_table.sv @@
// peer presence aging table: key/stamp memory with fused aging sweep and lookup
// depends on ppat_pkg and peer_presence_aging_table_defines.svh
//
// channel    dir  handshake                    payload
// s_axis     in   tvalid / tready              tuser opcode, tdata peer_key
// m_axis     out  tvalid / tready              tdata active_count .. removed_count
// cfg        in   i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// tick item: the transfer moves to S_RESULT, which loads the result register once m_axis is free
// announce item: S_SCAN over the stored entries, then S_FINISH and S_RESULT; one read and at most one write per cycle
// the scan is a single read/modify/write pass over the table
// reset clears counters and registers only, no clearing pass of the memory
// a result waiting on m_axis holds the block after its next item is done
`include "peer_presence_aging_table_defines.svh"

module peer_presence_aging_table #(
    parameter int TABLE_DEPTH = ppat_pkg::TABLE_DEPTH_DEFAULT,
    parameter int KEY_BITS    = ppat_pkg::KEY_BITS_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // peer_key
    input  logic [((KEY_BITS+7)/8)*8-1:0]        i_s_axis_tdata,
    // opcode
    input  logic                                 i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // active_count, was_new, dropped_full, removed_count, zero fill
    output logic [ppat_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic                                 i_cfg_index,
    input  logic [ppat_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import ppat_pkg::*;

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W = KEY_BITS + STAMP_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH, S_RESULT} t_state;

    t_state                  r_state;
    logic [ENT_W-1:0]        r_mem [TABLE_DEPTH];
    logic [ENT_W-1:0]        r_mem_q;
    logic [STAMP_W-1:0]      r_live_timeout;
    logic [STAMP_W-1:0]      r_check_interval;
    logic [STAMP_W-1:0]      r_now;
    logic [STAMP_W-1:0]      r_last_sweep;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_n;
    logic [CW-1:0]           r_rd;
    logic [CW-1:0]           r_wr;
    logic [CW-1:0]           r_removed;
    logic                    r_pend;
    logic                    r_sweep;
    logic                    r_found;
    logic                    r_res_new;
    logic                    r_res_drop;
    logic [KEY_BITS-1:0]     r_key;
    logic                    r_out_valid;
    logic [OUT_TDATA_W-1:0]  r_out_tdata;

    logic                    s_xfer;
    logic                    rd_en;
    logic                    we;
    logic [AW-1:0]           waddr;
    logic [ENT_W-1:0]        wdata;
    logic [KEY_BITS-1:0]     q_key;
    logic [STAMP_W-1:0]      q_stamp;
    logic [STAMP_W-1:0]      q_age;
    logic                    q_alive;
    logic                    q_match;
    logic                    room;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_xfer          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_tdata;

    assign rd_en   = (r_state == S_SCAN) && (r_rd < r_n);
    assign q_key   = r_mem_q[ENT_W-1:STAMP_W];
    assign q_stamp = r_mem_q[STAMP_W-1:0];
    assign q_age   = r_now - q_stamp;
    assign q_alive = !r_sweep || (q_age <= r_live_timeout);
    assign q_match = (q_key == r_key);
    assign room    = (r_wr < DEPTH_C);

    always_comb begin
        we    = 1'b0;
        waddr = r_wr[AW-1:0];
        wdata = {r_key, r_now};
        if (r_state == S_SCAN && r_pend && q_alive) begin
            // compacted copy, stamp refreshed on key match
            we    = 1'b1;
            wdata = {q_key, q_match ? r_now : q_stamp};
        end else if (r_state == S_FINISH && !r_found && room) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[r_rd[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_out_valid      <= 1'b0;
            r_count          <= '0;
            r_now            <= '0;
            r_last_sweep     <= '0;
            r_live_timeout   <= RESET_TIMEOUT;
            r_check_interval <= RESET_TIMEOUT;
            r_pend           <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_LIVE_TIMEOUT:   r_live_timeout   <= i_cfg_data;
                    CFG_CHECK_INTERVAL: r_check_interval <= i_cfg_data;
                    default:            r_live_timeout   <= r_live_timeout;
                endcase
            end
            if (r_out_valid && i_m_axis_tready && r_state != S_RESULT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_xfer) begin
                        if (i_s_axis_tuser == OP_TICK) begin
                            r_now      <= r_now + 1'b1;
                            r_res_new  <= 1'b0;
                            r_res_drop <= 1'b0;
                            r_removed  <= '0;
                            r_state    <= S_RESULT;
                        end else begin
                            r_key   <= i_s_axis_tdata[KEY_BITS-1:0];
                            r_sweep <= (r_now - r_last_sweep) > r_check_interval;
                            r_n     <= r_count;
                            r_rd    <= '0;
                            r_wr    <= '0;
                            r_pend  <= 1'b0;
                            r_found <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_pend <= rd_en;
                    if (rd_en) begin
                        r_rd <= r_rd + 1'b1;
                    end
                    if (r_pend && q_alive) begin
                        r_wr <= r_wr + 1'b1;
                        if (q_match) begin
                            r_found <= 1'b1;
                        end
                    end
                    if (!rd_en && !r_pend) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    r_removed <= r_n - r_wr;
                    if (r_sweep) begin
                        r_last_sweep <= r_now;
                    end
                    if (r_found) begin
                        r_count    <= r_wr;
                        r_res_new  <= 1'b0;
                        r_res_drop <= 1'b0;
                    end else if (room) begin
                        r_count    <= r_wr + 1'b1;
                        r_res_new  <= 1'b1;
                        r_res_drop <= 1'b0;
                    end else begin
                        r_count    <= r_wr;
                        r_res_new  <= 1'b0;
                        r_res_drop <= 1'b1;
                    end
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_tdata <= {2'b00, CNT_OUT_W'(r_removed), r_res_drop,
                                        r_res_new, CNT_OUT_W'(r_count)};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `PPAT_ASSERT_NOW(a_count_bound, 1'b1, r_count <= DEPTH_C, "entry count beyond depth")
    `PPAT_ASSERT_NOW(a_wr_behind_rd, r_state == S_SCAN && r_pend, r_wr < r_rd,
        "compaction write overtakes read")
    `PPAT_ASSERT_NOW(a_new_or_drop, r_state == S_RESULT, !(r_res_new && r_res_drop),
        "new and dropped flags both set")
    `PPAT_ASSERT_NXT(a_busy_after_xfer, s_xfer, !o_s_axis_tready,
        "input ready right after a transfer")

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench for peer_presence_aging_table: tick and announce traffic on the
// input stream, per-item reports checked against a table predictor, config writes between
// phases; depends only on ppat_pkg and the block itself
module testbench;
    import ppat_pkg::*;

    localparam int KEY_W  = 48;
    localparam int DEPTH  = 32;
    localparam int POOL_N = 64;

    typedef struct packed {
        logic [5:0] removed_count;
        logic       dropped_full;
        logic       was_new;
        logic [5:0] active_count;
    } t_presence_report;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [KEY_W-1:0]  i_s_axis_tdata = '0;
    logic              i_s_axis_tuser = OP_TICK;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_index = CFG_LIVE_TIMEOUT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // predicted table contents and settings
    logic [KEY_W-1:0]  table_keys [DEPTH];
    logic [31:0]       table_stamps [DEPTH];
    int                table_held = 0;
    logic [31:0]       tick_now = '0;
    logic [31:0]       last_sweep = '0;
    logic [31:0]       timeout_reg = RESET_TIMEOUT;
    logic [31:0]       interval_reg = RESET_TIMEOUT;

    t_presence_report  expected_reports [$];
    logic [KEY_W-1:0]  key_pool [POOL_N];
    int                error_count = 0;
    int                rx_hold_cycles = 0;
    bit                no_idle = 1'b0;

    peer_presence_aging_table DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #400000;
        $display("FAIL");
        $finish;
    end

    function automatic int pick_gap();
        return no_idle ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic t_presence_report update_presence(input logic op,
                                                         input logic [KEY_W-1:0] key);
        t_presence_report rep;
        logic [31:0] age;
        int wr;
        int removed;
        bit found;
        rep = '0;
        removed = 0;
        found = 1'b0;
        if (op == OP_TICK) begin
            tick_now = tick_now + 32'd1;
        end else begin
            if ((tick_now - last_sweep) > interval_reg) begin
                wr = 0;
                for (int rd = 0; rd < table_held; rd++) begin
                    age = tick_now - table_stamps[rd];
                    if (age <= timeout_reg) begin
                        table_keys[wr] = table_keys[rd];
                        table_stamps[wr] = table_stamps[rd];
                        wr++;
                    end
                end
                removed = table_held - wr;
                table_held = wr;
                last_sweep = tick_now;
            end
            for (int i = 0; i < table_held && !found; i++) begin
                if (table_keys[i] == key) begin
                    table_stamps[i] = tick_now;
                    found = 1'b1;
                end
            end
            if (!found) begin
                if (table_held < DEPTH) begin
                    table_keys[table_held] = key;
                    table_stamps[table_held] = tick_now;
                    table_held++;
                    rep.was_new = 1'b1;
                end else begin
                    rep.dropped_full = 1'b1;
                end
            end
        end
        rep.active_count = 6'(table_held);
        rep.removed_count = 6'(removed);
        return rep;
    endfunction

    task automatic check_report(input logic [OUT_TDATA_W-1:0] word);
        t_presence_report want;
        if (expected_reports.size() == 0) begin
            $display("%0t unexpected report expected none actual %h", $time, word);
            error_count++;
        end else begin
            want = expected_reports.pop_front();
            if (word[5:0] !== want.active_count) begin
                $display("%0t active_count expected %0d actual %0d", $time,
                         want.active_count, word[5:0]);
                error_count++;
            end
            if (word[6] !== want.was_new) begin
                $display("%0t was_new expected %0d actual %0d", $time, want.was_new, word[6]);
                error_count++;
            end
            if (word[7] !== want.dropped_full) begin
                $display("%0t dropped_full expected %0d actual %0d", $time,
                         want.dropped_full, word[7]);
                error_count++;
            end
            if (word[13:8] !== want.removed_count) begin
                $display("%0t removed_count expected %0d actual %0d", $time,
                         want.removed_count, word[13:8]);
                error_count++;
            end
        end
    endtask

    // result side: per-report stall, optional long hold-off
    initial begin : result_sink
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                check_report(o_m_axis_tdata);
                stall = pick_gap();
            end
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                i_m_axis_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // valid stays high after a transfer so that a gapless next item follows directly;
    // anything else that lets time pass lowers it first
    task automatic send_item(input logic op, input logic [KEY_W-1:0] key);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= op;
        i_s_axis_tdata <= key;
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_reports.push_back(update_presence(op, key));
    endtask

    task automatic drain();
        if (i_s_axis_tvalid)
            i_s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_LIVE_TIMEOUT)
            timeout_reg = value;
        else
            interval_reg = value;
        @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] random_key();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[KEY_W-1:0];
    endfunction

    // random keys drawn from a pool a little larger than the table, plus some one-off keys
    task automatic random_traffic(input int count, input int tick_pct, input int pool_n);
        logic [KEY_W-1:0] key;
        for (int i = 0; i < pool_n; i++) key_pool[i] = random_key();
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) == 0)
                key = random_key();
            else
                key = key_pool[$urandom_range(0, pool_n - 1)];
            if ($urandom_range(0, 99) < tick_pct)
                send_item(OP_TICK, key);
            else
                send_item(OP_ANNOUNCE, key);
        end
    endtask

    task automatic test_defaults();
        send_item(OP_ANNOUNCE, '0);
        send_item(OP_ANNOUNCE, '1);
        send_item(OP_ANNOUNCE, '0);
        send_item(OP_TICK, '1);
    endtask

    task automatic test_sweep_removal();
        write_reg(CFG_LIVE_TIMEOUT, 32'd2);
        write_reg(CFG_CHECK_INTERVAL, 32'd0);
        send_item(OP_ANNOUNCE, 48'h0123_4567_89AB);
        repeat (3) send_item(OP_TICK, '0);
        send_item(OP_ANNOUNCE, 48'hA5A5_5A5A_C3C3);
    endtask

    task automatic test_zero_timeout();
        write_reg(CFG_LIVE_TIMEOUT, 32'd0);
        send_item(OP_TICK, 48'h8000_0000_0001);
        send_item(OP_ANNOUNCE, 48'hFEDC_BA98_7654);
        send_item(OP_ANNOUNCE, 48'hFEDC_BA98_7654);
        send_item(OP_TICK, '0);
        send_item(OP_ANNOUNCE, 48'h0000_0000_0001);
    endtask

    task automatic test_fill_and_drop();
        write_reg(CFG_LIVE_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(CFG_CHECK_INTERVAL, 32'hFFFF_FFFF);
        random_traffic(70, 10, 48);
    endtask

    task automatic test_aging_sweeps();
        write_reg(CFG_LIVE_TIMEOUT, 32'd20);
        write_reg(CFG_CHECK_INTERVAL, 32'd10);
        random_traffic(150, 40, 40);
    endtask

    task automatic test_back_to_back();
        write_reg(CFG_LIVE_TIMEOUT, 32'd1);
        write_reg(CFG_CHECK_INTERVAL, 32'd0);
        no_idle = 1'b1;
        random_traffic(100, 50, 36);
        drain();
        no_idle = 1'b0;
    endtask

    task automatic test_reset_settings();
        write_reg(CFG_LIVE_TIMEOUT, RESET_TIMEOUT);
        write_reg(CFG_CHECK_INTERVAL, RESET_TIMEOUT);
        random_traffic(120, 45, 40);
    endtask

    task automatic test_random_settings();
        repeat (4) begin
            write_reg(CFG_LIVE_TIMEOUT, 32'($urandom_range(1, 40)));
            write_reg(CFG_CHECK_INTERVAL, 32'($urandom_range(0, 30)));
            random_traffic(50, 35, $urandom_range(33, POOL_N));
        end
    endtask

    // result side holds off while items keep coming, then the source waits for all reports
    task automatic test_backpressure();
        write_reg(CFG_LIVE_TIMEOUT, 32'd15);
        write_reg(CFG_CHECK_INTERVAL, 32'd5);
        rx_hold_cycles = 300;
        random_traffic(30, 30, 36);
        drain();
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            table_keys[i] = '0;
            table_stamps[i] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_sweep_removal();
        test_zero_timeout();
        test_fill_and_drop();
        test_aging_sweeps();
        test_back_to_back();
        test_reset_settings();
        test_random_settings();
        test_backpressure();
        drain();
        repeat (40) @(posedge i_clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/ppat_pkg.sv
sv/peer_presence_aging_table.sv
verif/testbench.sv
